FILE: sv/abla_pkg.sv
// ----------------------------------------------------------------------------
// abla_pkg: shared types and constants of the band level analyzer
// Filter coefficients, band gains, smoothing rates and sequencer states.
// ----------------------------------------------------------------------------
package abla_pkg;

    localparam int NUM_BANDS_C        = 16;
    localparam int MAX_BLOCK_FRAMES_C = 4096;
    localparam int NUM_LP             = 15;

    localparam logic [12:0] FULL_Q12 = 13'd4096;
    localparam logic [16:0] BASS_COEF = 17'd1180;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_FLT_RD,
        S_FLT_MUL,
        S_FLT_WR,
        S_B15_RD,
        S_B15_WR,
        S_LVL_WR,
        S_FIN_RD,
        S_FIN_MUL,
        S_FIN_START,
        S_FIN_DIV,
        S_FIN_SM,
        S_FIN_OUT
    } t_state;

    // Filter coefficient for step k: 0 is bass, 1..15 are band lowpasses.
    function automatic logic [16:0] f_coef(input logic [4:0] k);
        logic [16:0] c;
        unique case (k)
            5'd0:  c = BASS_COEF;
            5'd1:  c = 17'd524;
            5'd2:  c = 17'd852;
            5'd3:  c = 17'd1311;
            5'd4:  c = 17'd1966;
            5'd5:  c = 17'd2949;
            5'd6:  c = 17'd4325;
            5'd7:  c = 17'd6423;
            5'd8:  c = 17'd9110;
            5'd9:  c = 17'd12583;
            5'd10: c = 17'd17629;
            5'd11: c = 17'd23986;
            5'd12: c = 17'd31523;
            5'd13: c = 17'd39584;
            5'd14: c = 17'd47383;
            5'd15: c = 17'd53674;
            default: c = 17'd0;
        endcase
        return c;
    endfunction

    // Numerator and denominator of the target gain for result index i.
    function automatic logic [7:0] f_num(input logic [4:0] i);
        logic [7:0] n;
        unique case (i)
            5'd0:  n = 8'd2;
            5'd1:  n = 8'd13;
            5'd2:  n = 8'd10;
            5'd3:  n = 8'd12;
            5'd4:  n = 8'd15;
            5'd5:  n = 8'd18;
            5'd6:  n = 8'd22;
            5'd7:  n = 8'd26;
            5'd8:  n = 8'd32;
            5'd9:  n = 8'd38;
            5'd10: n = 8'd46;
            5'd11: n = 8'd54;
            5'd12: n = 8'd64;
            5'd13: n = 8'd76;
            5'd14: n = 8'd90;
            5'd15: n = 8'd108;
            5'd16: n = 8'd128;
            5'd17: n = 8'd152;
            default: n = 8'd0;
        endcase
        return n;
    endfunction

    function automatic logic [4:0] f_den(input logic [4:0] i);
        return (i == 5'd0) ? 5'd5 : 5'd16;
    endfunction

    function automatic logic [16:0] f_rate(input logic [4:0] i, input logic up);
        logic [16:0] r;
        if (i == 5'd0)      r = up ? 17'd32768 : 17'd7864;
        else if (i == 5'd1) r = up ? 17'd39322 : 17'd6554;
        else                r = up ? 17'd36045 : 17'd9175;
        return r;
    endfunction

endpackage

FILE: sv/abla_div.sv
// ----------------------------------------------------------------------------
// abla_div: restoring divider
// Unsigned 40 by 18 bit division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module abla_div
    import abla_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [39:0] i_num,
    input  logic [17:0] i_den,
    output logic        o_done,
    output logic [39:0] o_quot
);

    logic [39:0] r_quot, n_quot;
    logic [18:0] r_rem, n_rem;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic [17:0] r_den;
    logic [18:0] w_try;

    always_comb begin
        n_quot = r_quot;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        w_try  = {r_rem[17:0], r_quot[39]};
        if (i_start) begin
            n_quot = i_num;
            n_rem  = '0;
            n_cnt  = 6'd40;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_try >= {1'b0, r_den}) begin
                n_rem  = w_try - {1'b0, r_den};
                n_quot = {r_quot[38:0], 1'b1};
            end else begin
                n_rem  = w_try;
                n_quot = {r_quot[38:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        if (i_start) r_den <= i_den;
    end

    assign o_done = r_busy && (r_cnt == 6'd1) && !i_start;
    assign o_quot = n_quot;

endmodule

FILE: sv/audio_band_level_analyzer.sv
// ----------------------------------------------------------------------------
// audio_band_level_analyzer: stereo level, bass and 16-band analyzer
//
// Input beats carry a command, a stereo PCM pair and a block-end mark. A
// sample beat averages the pair to mono, runs the bass lowpass and 15 band
// lowpasses through one shared multiplier and adds the magnitudes to their
// block sums. Filter states, sums and smoothed values live in one memory,
// read before they are modified and written back.
// Each filter of a sample passes a read, a multiply and a write state, then
// the last band sum and the level sum are written; the next beat is taken
// once the sequencer is back in idle. On the final sample of a block (or when
// 4096 frames have gathered) 18 results follow; each needs a read, a
// multiply, a divider start, a divide, a smoothing write and an output beat.
// A clear beat zeroes every entry, one per cycle. Reset clears the control
// state and then runs the same clearing pass, during which no input beat is
// taken. A stalled output beat holds the sequencer, and no new input is
// taken until all 18 results are gone.
// ----------------------------------------------------------------------------
module audio_band_level_analyzer
    import abla_pkg::*;
#(
    parameter int MAX_BLOCK_FRAMES = MAX_BLOCK_FRAMES_C
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_cmd,
    input  logic signed [15:0] i_left_sample,
    input  logic signed [15:0] i_right_sample,
    input  logic               i_last_of_block,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [4:0]         o_value_index,
    output logic [12:0]        o_smoothed_value,
    output logic               o_last_value
);

    // Memory map: 0..15 filters (0 bass), 16..33 sums (16 level, 17 bass,
    // 18.. bands), 34..51 smoothed values. Clearing sweeps 0..51.
    localparam int DEPTH = 52;
    localparam int FW    = $clog2(MAX_BLOCK_FRAMES + 1);

    localparam logic [5:0] A_SUM      = 6'd16;
    localparam logic [5:0] A_BASS_SUM = 6'd17;
    localparam logic [5:0] A_BAND14   = 6'd32;
    localparam logic [5:0] A_BAND15   = 6'd33;
    localparam logic [5:0] A_SMOOTH   = 6'd34;
    localparam logic [5:0] A_LAST     = 6'(DEPTH - 1);
    localparam logic [4:0] K_LAST_FLT = 5'd15;
    localparam logic [4:0] K_LAST_RES = 5'd17;

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rd;
    logic [5:0]  w_ra, w_wa;
    logic        w_we;
    logic [31:0] w_wd;

    t_state        r_state, n_state;
    logic [4:0]    r_k, n_k;
    logic [5:0]    r_clr, n_clr;
    logic [FW-1:0] r_frames, n_frames;
    logic          r_close, n_close;

    logic signed [31:0] r_mq;
    logic [16:0] r_lvl;
    logic [31:0] r_s;
    logic [31:0] r_prod;
    logic [31:0] r_prev;  // previous lowpass of this sample
    logic [31:0] r_swd;
    logic [39:0] r_divn;
    logic [12:0] r_tgt, r_sm, r_oldsm;

    logic signed [16:0] w_mono;
    logic [16:0] w_lvl;
    logic signed [32:0] w_diff;
    logic signed [50:0] w_prod;
    logic [31:0] w_newf;
    logic [32:0] w_d, w_mag;
    logic [32:0] w_d15, w_mag15;
    logic [16:0] w_magi, w_mag15i;
    logic        w_dstart, w_ddone;
    logic [39:0] w_quot;
    logic [17:0] w_den;
    logic [12:0] w_tq;
    logic [16:0] w_rate;
    logic [30:0] w_sm;

    assign w_mono = $signed({i_left_sample[15], i_left_sample} +
                            {i_right_sample[15], i_right_sample}) >>> 1;
    assign w_lvl  = w_mono[16] ? -w_mono : w_mono;

    assign w_diff = {r_mq[31], r_mq} - {r_rd[31], r_rd};
    assign w_prod = 51'(w_diff) * 51'($signed({1'b0, f_coef(r_k)}));
    assign w_newf = r_s + r_prod;

    // Steps 0 and 1 take the lowpass itself, later steps the difference to
    // the lowpass of the step before.
    assign w_d    = (r_k <= 5'd1) ? {w_newf[31], w_newf}
                                  : {w_newf[31], w_newf} - {r_prev[31], r_prev};
    assign w_mag  = w_d[32] ? -w_d : w_d;
    assign w_magi = w_mag[32:16];

    assign w_d15    = {r_mq[31], r_mq} - {r_prev[31], r_prev};
    assign w_mag15  = w_d15[32] ? -w_d15 : w_d15;
    assign w_mag15i = w_mag15[32:16];

    assign w_den  = 18'(f_den(r_k)) * 18'(r_frames);
    assign w_tq   = (w_quot > 40'd4096) ? FULL_Q12 : w_quot[12:0];
    assign w_rate = f_rate(r_k, r_tgt > r_oldsm);
    assign w_sm   = 31'(r_oldsm) * 31'(17'd65536 - w_rate) + 31'(r_tgt) * 31'(w_rate);

    abla_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dstart),
        .i_num   (r_divn),
        .i_den   (w_den),
        .o_done  (w_ddone),
        .o_quot  (w_quot)
    );

    assign o_stall = (r_state != S_IDLE);

    // Next state.
    always_comb begin
        n_state  = r_state;
        n_k      = r_k;
        n_clr    = r_clr;
        n_frames = r_frames;
        n_close  = r_close;
        unique case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + 6'd1;
                if (r_clr == A_LAST) begin
                    n_clr   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: if (i_valid) begin
                if (i_cmd) begin
                    n_state  = S_CLEAR;
                    n_clr    = '0;
                    n_frames = '0;
                end else begin
                    n_state  = S_FLT_RD;
                    n_k      = '0;
                    n_frames = r_frames + FW'(1);
                    n_close  = i_last_of_block ||
                               (r_frames + FW'(1) >= FW'(MAX_BLOCK_FRAMES));
                end
            end
            S_FLT_RD:  n_state = S_FLT_MUL;
            S_FLT_MUL: n_state = S_FLT_WR;
            S_FLT_WR: begin
                if (r_k == K_LAST_FLT) begin
                    n_state = S_B15_RD;
                end else begin
                    n_k = r_k + 5'd1;
                    n_state = S_FLT_RD;
                end
            end
            S_B15_RD: n_state = S_B15_WR;
            S_B15_WR: n_state = S_LVL_WR;
            S_LVL_WR: begin
                n_k = '0;
                n_state = r_close ? S_FIN_RD : S_IDLE;
            end
            S_FIN_RD:    n_state = S_FIN_MUL;
            S_FIN_MUL:   n_state = S_FIN_START;
            S_FIN_START: n_state = S_FIN_DIV;
            S_FIN_DIV:   if (w_ddone) n_state = S_FIN_SM;
            S_FIN_SM:    n_state = S_FIN_OUT;
            S_FIN_OUT: if (!i_stall) begin
                if (r_k == K_LAST_RES) begin
                    n_state  = S_IDLE;
                    n_k      = '0;
                    n_frames = '0;
                end else begin
                    n_k = r_k + 5'd1;
                    n_state = S_FIN_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Memory addressing and writes. Each entry is read and then written back; a
    // band sum goes back in the read state of the next step, and no step touches the entry of another in flight.
    always_comb begin
        w_ra = 6'd0;
        w_we = 1'b0;
        w_wa = 6'd0;
        w_wd = '0;
        w_dstart = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                w_we = 1'b1;
                w_wa = r_clr;
            end
            S_FLT_RD: begin
                w_ra = 6'(r_k);
                // The sum of the previous step goes back while the port is free.
                if (r_k != 5'd0) begin
                    w_we = 1'b1;
                    w_wa = 6'(r_k) + A_SUM;
                    w_wd = r_swd;
                end
            end
            S_FLT_MUL: w_ra = 6'(r_k) + A_BASS_SUM;
            S_FLT_WR: begin
                w_we = 1'b1;
                w_wa = 6'(r_k);
                w_wd = w_newf;
            end
            S_B15_RD: begin
                w_ra = A_BAND15;
                w_we = 1'b1;
                w_wa = A_BAND14;
                w_wd = r_swd;
            end
            S_B15_WR: begin
                w_ra = A_SUM;
                w_we = 1'b1;
                w_wa = A_BAND15;
                w_wd = r_rd + 32'(w_mag15i);
            end
            S_LVL_WR: begin
                w_we = 1'b1;
                w_wa = A_SUM;
                w_wd = r_rd + 32'(r_lvl);
            end
            S_FIN_RD:    w_ra = 6'(r_k) + A_SUM;
            S_FIN_MUL:   w_ra = 6'(r_k) + A_SMOOTH;
            S_FIN_START: w_dstart = 1'b1;
            S_FIN_SM: begin
                w_we = 1'b1;
                w_wa = 6'(r_k) + A_SMOOTH;
                w_wd = 32'(w_sm[28:16]);
            end
            S_FIN_OUT: if (!i_stall) begin
                w_we = 1'b1;
                w_wa = 6'(r_k) + A_SUM;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_wa] <= w_wd;
        r_rd <= r_mem[w_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_k      <= '0;
            r_clr    <= '0;
            r_frames <= '0;
            r_close  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_k      <= n_k;
            r_clr    <= n_clr;
            r_frames <= n_frames;
            r_close  <= n_close;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid && !i_cmd) begin
            r_mq  <= {w_mono[15:0], 16'd0};
            r_lvl <= w_lvl;
        end
        if (r_state == S_FLT_MUL) begin
            r_s    <= r_rd;
            r_prod <= w_prod[47:16];
        end
        if (r_state == S_FLT_WR) begin
            r_prev <= w_newf;
            r_swd  <= r_rd + 32'(w_magi);
        end
        if (r_state == S_FIN_MUL) r_divn <= 40'(r_rd) * 40'(f_num(r_k));
        if (r_state == S_FIN_START) r_oldsm <= r_rd[12:0];
        if (r_state == S_FIN_DIV && w_ddone) r_tgt <= w_tq;
        if (r_state == S_FIN_SM) r_sm <= w_sm[28:16];
    end

    assign o_valid          = (r_state == S_FIN_OUT);
    assign o_value_index    = r_k;
    assign o_smoothed_value = r_sm;
    assign o_last_value     = (r_k == K_LAST_RES);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_value_index) &&
        $stable(o_smoothed_value) && $stable(o_last_value));

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_value_index <= K_LAST_RES) && (o_smoothed_value <= FULL_Q12));

    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid || r_state == S_CLEAR) |-> o_stall);

    a_frames: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frames <= FW'(MAX_BLOCK_FRAMES));

endmodule
